// ----- src/urdf_pkg.sv -----
// Package for the unsigned radix digit formatter.
// Holds the request and result structs, code constants and the digit encoder.
// No dependencies.
package urdf_pkg;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_LONG  = 2'd3;

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // x / 10 == (x * DEC_RECIP) >> DEC_SHIFT for x below 1029
  localparam logic [7:0] DEC_RECIP = 8'd205;
  localparam int         DEC_SHIFT = 11;
  localparam logic [3:0] DEC_BASE  = 4'd10;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_UPPER = 8'h41;
  localparam logic [7:0] ASCII_LOWER = 8'h61;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  size_code;
    logic [1:0]  radix_code;
    logic        capitals;
    logic        alternate;
    logic [6:0]  precision;
  } urdf_request_t;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
    logic [6:0] total_length;
    logic       octal_prefix;
    logic       hex_prefix;
  } urdf_result_t;

  typedef struct packed {
    logic        load;
    logic        next;
    logic [1:0]  radix_code;
    logic [63:0] value;
  } urdf_dig_cmd_t;

  typedef struct packed {
    logic       done;
    logic [3:0] digit;
    logic       more;
  } urdf_dig_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_OUT
  } urdf_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic caps);
    logic [7:0] base;
    if (d < DEC_BASE) begin
      digit_char = ASCII_ZERO + {4'd0, d};
    end else begin
      base = caps ? ASCII_UPPER : ASCII_LOWER;
      digit_char = base + {4'd0, d - DEC_BASE};
    end
  endfunction

endpackage

// ----- src/unsigned_radix_digit_formatter_unit.sv -----
// Top level of the unsigned radix digit formatter.
// Depends on urdf_pkg and urdf_digit_unit.
//
// Usage:
//   A request (value, size_code, radix_code, capitals, alternate, precision)
//   is taken on request_valid/request_ready; request_ready is high only when
//   the unit is idle, one request at a time.
//   Results leave on result_valid/result_ready from an output register,
//   least significant digit first, then '0' padding up to the precision,
//   capped at BUF_LEN characters. The result with last set closes the run
//   and carries the prefix flags. Zero value with zero precision gives a
//   single result with has_char clear.
//   Work per result: an octal or hex digit is a shift of the held quotient in
//   the digit unit, a decimal digit 16 nibble steps of its divide-by-ten unit;
//   each digit then needs the output load and the result handshake, a padding
//   character only the result handshake. A 64-bit value gives up to 20
//   decimal or 16 hex digits.
//   A stall on result_ready holds the current result and halts the run.
//   Synchronous reset returns the unit to idle and drops any run in flight.
module unsigned_radix_digit_formatter_unit
  import urdf_pkg::*;
#(
  parameter int BUF_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          request_valid,
  output logic          request_ready,
  input  urdf_request_t request,
  output logic          result_valid,
  input  logic          result_ready,
  output urdf_result_t  result
);

  localparam int CW = $clog2(BUF_LEN + 1);
  localparam logic [CW-1:0] BUF_MAX = CW'(BUF_LEN);

  urdf_state_t    state, state_next;
  urdf_dig_cmd_t  dig_cmd;
  urdf_dig_stat_t dig_stat;

  logic [CW-1:0] count;
  logic [CW-1:0] prec;
  logic          caps;
  logic          oct_flag;
  logic          hex_flag;
  logic          pad_mode;
  urdf_result_t  out_r;

  logic          req_acc;
  logic          res_acc;
  logic [63:0]   v_trunc;
  logic          v_zero;
  logic [CW-1:0] prec_sat;
  logic [CW-1:0] cnt1;
  logic          more;
  logic          pad;

  assign req_acc = request_valid && request_ready;
  assign res_acc = result_valid && result_ready;
  assign cnt1    = count + CW'(1);

  always_comb begin
    unique case (request.size_code)
      SIZE_BYTE:  v_trunc = {56'd0, request.value[7:0]};
      SIZE_SHORT: v_trunc = {48'd0, request.value[15:0]};
      SIZE_WORD:  v_trunc = {32'd0, request.value[31:0]};
      default:    v_trunc = request.value;
    endcase
    v_zero   = (v_trunc == '0);
    prec_sat = (request.precision > 7'(BUF_LEN)) ? BUF_MAX : CW'(request.precision);
    more     = dig_stat.more && (cnt1 < BUF_MAX);
    pad      = (cnt1 < prec);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          state_next = (v_zero && prec_sat == '0) ? ST_OUT : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (dig_stat.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_acc) begin
          if (out_r.last) begin
            state_next = ST_IDLE;
          end else if (!pad_mode) begin
            state_next = ST_DIGIT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request_ready      = (state == ST_IDLE);
    result_valid       = (state == ST_OUT);
    dig_cmd.load       = req_acc;
    dig_cmd.next       = res_acc && !out_r.last && !pad_mode;
    dig_cmd.radix_code = request.radix_code;
    dig_cmd.value      = v_trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pad_mode <= 1'b0;
    end else begin
      if (req_acc) begin
        count    <= '0;
        pad_mode <= 1'b0;
        prec     <= prec_sat;
        caps     <= request.capitals;
        oct_flag <= request.alternate && !v_zero && (request.radix_code == RADIX_OCT);
        hex_flag <= request.alternate && !v_zero && (request.radix_code == RADIX_HEX);
        out_r    <= '{character: 8'd0, has_char: 1'b0, last: 1'b1, total_length: 7'd0,
                      octal_prefix: 1'b0, hex_prefix: 1'b0};
      end else if (state == ST_DIGIT && dig_stat.done) begin
        count    <= cnt1;
        pad_mode <= !more;
        out_r    <= '{character: digit_char(dig_stat.digit, caps), has_char: 1'b1,
                      last: !more && !pad, total_length: 7'(cnt1),
                      octal_prefix: oct_flag && !more && !pad,
                      hex_prefix: hex_flag && !more && !pad};
      end else if (res_acc && !out_r.last && pad_mode) begin
        count <= cnt1;
        out_r <= '{character: ASCII_ZERO, has_char: 1'b1, last: (cnt1 >= prec),
                   total_length: 7'(cnt1),
                   octal_prefix: oct_flag && (cnt1 >= prec),
                   hex_prefix: hex_flag && (cnt1 >= prec)};
      end
    end
  end

  assign result = out_r;

  urdf_digit_unit u_digit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dig_cmd),
    .stat (dig_stat)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= BUF_MAX)
    else $error("character count beyond buffer length");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    res_acc && result.last |=> request_ready)
    else $error("unit not idle after last result");

  a_length_with_char: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.has_char |-> result.total_length != 7'd0)
    else $error("character result with zero length");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIGIT |-> !dig_cmd.load && !dig_cmd.next)
    else $error("digit unit restarted mid-digit");

endmodule

// ----- src/urdf_digit_unit.sv -----
// Digit extractor: peels the least significant digit off a held quotient.
// Octal and hex shift the digit straight out of the quotient; decimal divides by ten a nibble per cycle.
// Depends on urdf_pkg.
module urdf_digit_unit
  import urdf_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  urdf_dig_cmd_t  cmd,
  output urdf_dig_stat_t stat
);

  logic [63:0] sh;
  logic [3:0]  rem;
  logic [3:0]  cnt;
  logic        busy;
  logic        done;
  logic [1:0]  radix;

  logic [7:0]  x;
  logic [15:0] prod;
  logic [3:0]  q;
  logic [7:0]  qx10;
  logic [3:0]  r;

  always_comb begin
    x    = {rem, sh[63:60]};
    prod = 16'(x) * 16'(DEC_RECIP);
    q    = prod[DEC_SHIFT+3:DEC_SHIFT];
    qx10 = 8'(q) * 8'(DEC_BASE);
    r    = 4'(x - qx10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      priority if (cmd.load) begin
        sh    <= cmd.value;
        radix <= cmd.radix_code;
        rem   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (cmd.next) begin
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        unique case (radix)
          RADIX_OCT: begin
            rem  <= {1'b0, sh[2:0]};
            sh   <= sh >> 3;
            busy <= 1'b0;
            done <= 1'b1;
          end
          RADIX_HEX: begin
            rem  <= sh[3:0];
            sh   <= sh >> 4;
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: begin
            sh  <= {sh[59:0], q};
            rem <= r;
            cnt <= cnt + 4'd1;
            if (cnt == 4'hF) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign stat.done  = done;
  assign stat.digit = rem;
  assign stat.more  = (sh != '0);

endmodule

// ----- test/unsigned_radix_digit_formatter_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for unsigned_radix_digit_formatter_unit: directed and random conversion requests,
// with the expected characters worked out in the bench and checked in order.
// Depends on urdf_pkg and the formatter RTL.
module unsigned_radix_digit_formatter_unit_tb;
  import urdf_pkg::*;

  localparam int BUF_LEN = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [127:0] DIGITS_LOWER = "0123456789abcdef";
  localparam logic [127:0] DIGITS_UPPER = "0123456789ABCDEF";
  localparam logic [7:0] CHAR_ZERO = "0";
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [1:0] RADIX_SPARE = 2'd3;

  logic          clk;
  logic          rst;
  logic          request_valid;
  logic          request_ready;
  urdf_request_t request;
  logic          result_valid;
  logic          result_ready;
  urdf_result_t  result;

  urdf_result_t pending_chars[$];
  int error_count = 0;
  int idle_cycles = 0;
  int hold_off_cycles = 0;
  bit no_idle = 1'b0;

  unsigned_radix_digit_formatter_unit #(
    .BUF_LEN(BUF_LEN)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_ready(request_ready),
    .request      (request),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic urdf_result_t digit_result(logic [7:0] ch, int count);
    urdf_result_t r;
    r = '0;
    r.character = ch;
    r.has_char = 1'b1;
    r.total_length = count[6:0];
    return r;
  endfunction

  function automatic void predict_conversion(urdf_request_t req);
    logic [63:0] v;
    logic [63:0] base;
    logic [63:0] rem;
    logic [7:0]  ch;
    logic        oct_flag;
    logic        hex_flag;
    int          prec;
    int          count;
    int          idx;
    urdf_result_t held;
    case (req.size_code)
      SIZE_BYTE:  v = {56'd0, req.value[7:0]};
      SIZE_SHORT: v = {48'd0, req.value[15:0]};
      SIZE_WORD:  v = {32'd0, req.value[31:0]};
      default:    v = req.value;
    endcase
    prec = (req.precision > BUF_LEN) ? BUF_LEN : int'(req.precision);
    held = '0;
    if (v == 64'd0 && prec == 0) begin
      held.last = 1'b1;
      pending_chars.push_back(held);
      return;
    end
    oct_flag = req.alternate && v != 64'd0 && req.radix_code == RADIX_OCT;
    hex_flag = req.alternate && v != 64'd0 && req.radix_code == RADIX_HEX;
    case (req.radix_code)
      RADIX_OCT: base = 64'd8;
      RADIX_HEX: base = 64'd16;
      default:   base = 64'd10;
    endcase
    count = 0;
    do begin
      if (count > 0) pending_chars.push_back(held);
      rem = v % base;
      v = v / base;
      count++;
      idx = 8 * (15 - int'(rem[3:0]));
      ch = req.capitals ? DIGITS_UPPER[idx +: 8] : DIGITS_LOWER[idx +: 8];
      held = digit_result(ch, count);
    end while (v != 64'd0 && count < BUF_LEN);
    while (count < prec && count < BUF_LEN) begin
      pending_chars.push_back(held);
      count++;
      held = digit_result(CHAR_ZERO, count);
    end
    held.last = 1'b1;
    held.octal_prefix = oct_flag;
    held.hex_prefix = hex_flag;
    pending_chars.push_back(held);
  endfunction

  function automatic urdf_request_t make_request(logic [63:0] value, logic [1:0] size_code,
                                                 logic [1:0] radix_code, logic capitals,
                                                 logic alternate, logic [6:0] precision);
    urdf_request_t req;
    req.value = value;
    req.size_code = size_code;
    req.radix_code = radix_code;
    req.capitals = capitals;
    req.alternate = alternate;
    req.precision = precision;
    return req;
  endfunction

  function automatic urdf_request_t random_request();
    urdf_request_t req;
    int shift;
    shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63);
    req.value = {$urandom, $urandom} >> shift;
    req.size_code = 2'($urandom_range(0, 3));
    req.radix_code = 2'($urandom_range(0, 3));
    req.capitals = 1'($urandom_range(0, 1));
    req.alternate = 1'($urandom_range(0, 1));
    req.precision = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 20));
    return req;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(urdf_request_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_valid <= 1'b1;
    request <= req;
    do @(posedge clk); while (!request_ready);
    predict_conversion(req);
    @(negedge clk);
  endtask

  task automatic test_edge_values();
    send_request(make_request(64'd0, SIZE_LONG, RADIX_OCT, 1'b0, 1'b0, 7'd0));
    send_request(make_request(64'd0, SIZE_LONG, RADIX_DEC, 1'b0, 1'b1, 7'd0));
    send_request(make_request(64'd0, SIZE_BYTE, RADIX_HEX, 1'b1, 1'b1, 7'd0));
    send_request(make_request(64'd0, SIZE_WORD, RADIX_DEC, 1'b0, 1'b0, 7'd1));
    send_request(make_request(64'd0, SIZE_SHORT, RADIX_HEX, 1'b0, 1'b1, 7'd5));
    send_request(make_request(ALL_ONES, SIZE_LONG, RADIX_OCT, 1'b0, 1'b1, 7'd0));
    send_request(make_request(ALL_ONES, SIZE_LONG, RADIX_DEC, 1'b1, 1'b1, 7'd0));
    send_request(make_request(ALL_ONES, SIZE_LONG, RADIX_HEX, 1'b1, 1'b1, 7'd0));
    send_request(make_request(ALL_ONES, SIZE_LONG, RADIX_HEX, 1'b0, 1'b0, 7'd3));
    send_request(make_request(ALL_ONES, SIZE_BYTE, RADIX_HEX, 1'b1, 1'b1, 7'd0));
    send_request(make_request(ALL_ONES, SIZE_SHORT, RADIX_DEC, 1'b0, 1'b0, 7'd0));
    send_request(make_request(ALL_ONES, SIZE_WORD, RADIX_OCT, 1'b0, 1'b1, 7'd0));
    send_request(make_request(64'h100, SIZE_BYTE, RADIX_HEX, 1'b0, 1'b1, 7'd0));
    send_request(make_request(64'h1_0000, SIZE_SHORT, RADIX_OCT, 1'b0, 1'b1, 7'd3));
    send_request(make_request(64'd12345, SIZE_LONG, RADIX_SPARE, 1'b1, 1'b1, 7'd0));
    send_request(make_request(64'd7, SIZE_LONG, RADIX_OCT, 1'b0, 1'b1, 7'd64));
    send_request(make_request(64'd9, SIZE_WORD, RADIX_DEC, 1'b0, 1'b0, 7'd65));
    send_request(make_request(64'hABC, SIZE_LONG, RADIX_HEX, 1'b1, 1'b1, 7'd127));
    send_request(make_request(64'd0, SIZE_LONG, RADIX_HEX, 1'b0, 1'b0, 7'd127));
    send_request(make_request(64'd1, SIZE_LONG, RADIX_DEC, 1'b0, 1'b1, 7'd2));
    send_request(make_request(64'hFEDC_BA98_7654_3210, SIZE_LONG, RADIX_HEX, 1'b0, 1'b1,
                              7'd10));
    send_request(make_request(64'h8000_0000_0000_0000, SIZE_LONG, RADIX_DEC, 1'b0, 1'b0,
                              7'd0));
    send_request(make_request(64'd1, SIZE_BYTE, RADIX_SPARE, 1'b1, 1'b0, 7'd24));
  endtask

  task automatic test_random_requests(int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (40) send_request(random_request());
    no_idle = 1'b0;
  endtask

  task automatic test_output_hold_off();
    hold_off_cycles = HOLD_OFF_CYCLES;
    repeat (15) send_request(random_request());
  endtask

  initial begin
    rst = 1'b1;
    request_valid = 1'b0;
    result_ready = 1'b0;
    request = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edge_values();
    test_random_requests(200);
    test_back_to_back();
    test_output_hold_off();
    test_random_requests(230);
    request_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    urdf_result_t expected;
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      if (pending_chars.size() == 0) begin
        $error("result with no conversion outstanding: %p", result);
        error_count++;
      end else begin
        expected = pending_chars.pop_front();
        if (result.character !== expected.character) begin
          $error("character: expected %h, got %h", expected.character, result.character);
          error_count++;
        end
        if (result.has_char !== expected.has_char) begin
          $error("has_char: expected %b, got %b", expected.has_char, result.has_char);
          error_count++;
        end
        if (result.last !== expected.last) begin
          $error("last: expected %b, got %b", expected.last, result.last);
          error_count++;
        end
        if (result.total_length !== expected.total_length) begin
          $error("total_length: expected %0d, got %0d", expected.total_length,
                 result.total_length);
          error_count++;
        end
        if (result.octal_prefix !== expected.octal_prefix) begin
          $error("octal_prefix: expected %b, got %b", expected.octal_prefix,
                 result.octal_prefix);
          error_count++;
        end
        if (result.hex_prefix !== expected.hex_prefix) begin
          $error("hex_prefix: expected %b, got %b", expected.hex_prefix, result.hex_prefix);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((request_valid && request_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
